// File: sv/mafe_pkg.sv
package mafe_pkg;

  localparam int unsigned FRAME_CHARS = 55;
  localparam int unsigned IDX_W       = 6;
  localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_CHARS - 1);
  localparam logic [IDX_W-1:0] CR_IDX     = IDX_W'(FRAME_CHARS - 2);

  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;

  localparam logic [7:0]  FUNC_CODE  = 8'h10;
  localparam logic [15:0] START_REG  = 16'h9900;
  localparam logic [15:0] REG_COUNT  = 16'h0009;
  localparam logic [7:0]  BYTE_COUNT = 8'h12;

  // Sum of the header bytes that never change (everything but the address)
  localparam logic [7:0] FIXED_SUM = FUNC_CODE + START_REG[15:8] + START_REG[7:0]
                                   + REG_COUNT[15:8] + REG_COUNT[7:0] + BYTE_COUNT;

  // Body byte positions that carry command data
  localparam logic [4:0] BYTE_ADDR     = 5'd0;
  localparam logic [4:0] BYTE_FUNC     = 5'd1;
  localparam logic [4:0] BYTE_START_HI = 5'd2;
  localparam logic [4:0] BYTE_START_LO = 5'd3;
  localparam logic [4:0] BYTE_CNT_HI   = 5'd4;
  localparam logic [4:0] BYTE_CNT_LO   = 5'd5;
  localparam logic [4:0] BYTE_BYTES    = 5'd6;
  localparam logic [4:0] BYTE_TGT_HI   = 5'd9;
  localparam logic [4:0] BYTE_TGT_LO   = 5'd10;
  localparam logic [4:0] BYTE_BAND_HI  = 5'd13;
  localparam logic [4:0] BYTE_BAND_LO  = 5'd14;
  localparam logic [4:0] BYTE_SPD_HI   = 5'd17;
  localparam logic [4:0] BYTE_SPD_LO   = 5'd18;
  localparam logic [4:0] BYTE_ACC_HI   = 5'd19;
  localparam logic [4:0] BYTE_ACC_LO   = 5'd20;
  localparam logic [4:0] BYTE_LRC      = 5'd25;

  typedef struct packed {
    logic [7:0]  station;
    logic [15:0] target_position;
    logic [15:0] position_band;
    logic [15:0] speed;
    logic [15:0] accel;
    logic [7:0]  lrc;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// File: sv/mafe_cmd_if.sv
interface mafe_cmd_if;
  logic        valid;
  logic        ready;
  logic [15:0] target_position;
  logic [15:0] position_band;
  logic [15:0] speed;
  logic [15:0] accel;

  modport source (output valid, output target_position, output position_band,
                  output speed, output accel, input ready);
  modport sink (input valid, input target_position, input position_band,
                input speed, input accel, output ready);
endinterface

// File: sv/mafe_char_if.sv
interface mafe_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink (input valid, input ascii_char, input last_char, output ready);
endinterface

// File: sv/modbus_ascii_move_frame_encoder.sv
// Channel  Dir  Beat                                          Accepted when
// cmd      in   target_position, position_band, speed, accel  cmd.valid && cmd.ready
// frame    out  ascii_char, last_char                         frame.valid && frame.ready
// cfg      in   cfg_wdata -> station_address (reset 1)        cfg_we
//
// Each command produces 55 characters, one per cycle while the sink is ready;
// the character serializer sets that rate.
// A taken command passes through the queue and the job register to the output.
// A two-entry command queue lets commands be taken while a frame is still going out.
// Reset is synchronous and clears the queue, the serializer and the output register.
// A stalled frame holds its character; the queue fills and then holds cmd.ready low.
module modbus_ascii_move_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  mafe_cmd_if.sink    cmd,
  mafe_char_if.source frame
);

  logic           [7:0] station;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_nonempty;
  mafe_pkg::job_t       wr_job;
  mafe_pkg::job_t       rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      station <= 8'd1;
    end else if (cfg_we) begin
      station <= cfg_wdata;
    end
  end

  mafe_front u_front (
    .cmd     (cmd),
    .station (station),
    .q_full  (q_full),
    .push    (push),
    .job     (wr_job)
  );

  mafe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .rd_job   (rd_job)
  );

  mafe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_job      (rd_job),
    .pop        (pop),
    .frame      (frame)
  );

endmodule

// File: sv/mafe_front.sv
module mafe_front (
  mafe_cmd_if.sink    cmd,
  input  logic [7:0]  station,
  input  logic        q_full,
  output logic        push,
  output mafe_pkg::job_t job
);

  logic [7:0] sum;

  assign cmd.ready = !q_full;
  assign push      = cmd.valid && !q_full;

  // Add the variable bytes to the fixed header sum, then negate for the LRC
  always_comb begin
    sum = mafe_pkg::FIXED_SUM + station
        + cmd.target_position[15:8] + cmd.target_position[7:0]
        + cmd.position_band[15:8] + cmd.position_band[7:0]
        + cmd.speed[15:8] + cmd.speed[7:0]
        + cmd.accel[15:8] + cmd.accel[7:0];
    job.station         = station;
    job.target_position = cmd.target_position;
    job.position_band   = cmd.position_band;
    job.speed           = cmd.speed;
    job.accel           = cmd.accel;
    job.lrc             = 8'd0 - sum;
  end

endmodule

// File: sv/mafe_queue.sv
module mafe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mafe_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output mafe_pkg::job_t rd_job
);

  mafe_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/mafe_back.sv
module mafe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  mafe_pkg::job_t q_job,
  output logic           pop,
  mafe_char_if.source    frame
);

  typedef enum logic {IDLE, EMIT} state_t;

  state_t                       state;
  mafe_pkg::job_t               job;
  logic [mafe_pkg::IDX_W-1:0]   idx;
  logic [mafe_pkg::IDX_W-1:0]   idx_m1;
  logic [4:0]                   byte_num;
  logic [7:0]                   byte_val;
  logic [7:0]                   char_next;
  logic                         advance;
  logic                         emit;
  logic                         at_last;

  assign advance = !frame.valid || frame.ready;
  assign emit    = (state == EMIT) && advance;
  assign at_last = (idx == mafe_pkg::LAST_IDX);
  assign pop     = q_nonempty && ((state == IDLE) || (emit && at_last));

  // Character k (1..52) shows body byte (k-1)/2, high nibble first
  assign idx_m1   = idx - mafe_pkg::IDX_ONE;
  assign byte_num = idx_m1[5:1];

  always_comb begin
    case (byte_num)
      mafe_pkg::BYTE_ADDR:     byte_val = job.station;
      mafe_pkg::BYTE_FUNC:     byte_val = mafe_pkg::FUNC_CODE;
      mafe_pkg::BYTE_START_HI: byte_val = mafe_pkg::START_REG[15:8];
      mafe_pkg::BYTE_START_LO: byte_val = mafe_pkg::START_REG[7:0];
      mafe_pkg::BYTE_CNT_HI:   byte_val = mafe_pkg::REG_COUNT[15:8];
      mafe_pkg::BYTE_CNT_LO:   byte_val = mafe_pkg::REG_COUNT[7:0];
      mafe_pkg::BYTE_BYTES:    byte_val = mafe_pkg::BYTE_COUNT;
      mafe_pkg::BYTE_TGT_HI:   byte_val = job.target_position[15:8];
      mafe_pkg::BYTE_TGT_LO:   byte_val = job.target_position[7:0];
      mafe_pkg::BYTE_BAND_HI:  byte_val = job.position_band[15:8];
      mafe_pkg::BYTE_BAND_LO:  byte_val = job.position_band[7:0];
      mafe_pkg::BYTE_SPD_HI:   byte_val = job.speed[15:8];
      mafe_pkg::BYTE_SPD_LO:   byte_val = job.speed[7:0];
      mafe_pkg::BYTE_ACC_HI:   byte_val = job.accel[15:8];
      mafe_pkg::BYTE_ACC_LO:   byte_val = job.accel[7:0];
      mafe_pkg::BYTE_LRC:      byte_val = job.lrc;
      default:                 byte_val = 8'h00;
    endcase

    if (idx == '0) begin
      char_next = mafe_pkg::CHAR_COLON;
    end else if (idx == mafe_pkg::CR_IDX) begin
      char_next = mafe_pkg::CHAR_CR;
    end else if (at_last) begin
      char_next = mafe_pkg::CHAR_LF;
    end else if (idx[0]) begin
      char_next = mafe_pkg::hex_char(byte_val[7:4]);
    end else begin
      char_next = mafe_pkg::hex_char(byte_val[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      idx              <= '0;
      frame.valid      <= 1'b0;
      frame.ascii_char <= 8'h00;
      frame.last_char  <= 1'b0;
    end else begin
      if (advance) begin
        frame.valid <= emit;
      end
      if (emit) begin
        frame.ascii_char <= char_next;
        frame.last_char  <= at_last;
      end
      case (state)
        IDLE: begin
          if (pop) begin
            state <= EMIT;
            idx   <= '0;
          end
        end
        EMIT: begin
          if (emit) begin
            if (at_last) begin
              // chain straight into the next queued frame
              state <= pop ? EMIT : IDLE;
              idx   <= '0;
            end else begin
              idx <= idx + mafe_pkg::IDX_ONE;
            end
          end
        end
        default: begin
          state <= IDLE;
          idx   <= '0;
        end
      endcase
    end
  end

endmodule
